@@ sv/tod_pkg.sv @@
// Shared types and constants for the time-of-day clock shift unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package tod_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,  // checked load
    MODE_LOAD  = 2'd1,  // normalized load
    MODE_SHIFT = 2'd2,  // move by signed offset
    MODE_DIFF  = 2'd3   // stored time minus operand
  } mode_t;

  // Classified request handed from front to back.
  // secs holds the operand (or offset) reduced modulo one day.
  typedef struct packed {
    mode_t       mode;
    logic        bad;
    logic [16:0] secs;
  } tod_item_t;

  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_DAY  = 86400;
  localparam int HOUR_MAX     = 23;
  localparam int MIN_MAX      = 59;
  localparam int SEC_MAX      = 59;

  // 86400 * 24856: smallest multiple of a day above 2^31, makes any operand positive
  localparam logic [33:0] DAY_BIAS = 34'd2147558400;

  // day = 2^7 * 675; reduction runs on the value shifted right by 7
  localparam int DAY_LO_BITS = 7;
  localparam int DAY_ODD     = 675;
  // ceil(2^36 / 675), exact quotient for 26-bit dividends
  localparam logic [26:0] RECIP_675 = 27'd101806633;
  localparam int          RECIP_675_SHIFT = 36;

  // hour = (secs >> 4) / 225 ; ceil(2^24 / 225)
  localparam logic [16:0] RECIP_225 = 17'd74566;
  localparam int          RECIP_225_SHIFT = 24;

  // minute = (rem >> 2) / 15 ; ceil(2^14 / 15)
  localparam logic [10:0] RECIP_15 = 11'd1093;
  localparam int          RECIP_15_SHIFT = 14;

endpackage

`default_nettype wire

@@ sv/tod_front.sv @@
// Front end: accepts requests, range-checks operands and reduces them modulo one day.
// Depends on tod_pkg; feeds tod_queue.
`default_nettype none

module tod_front import tod_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [15:0] in_hours_in,
  input  wire logic signed [15:0] in_minutes_in,
  input  wire logic signed [15:0] in_seconds_in,
  input  wire logic signed [31:0] in_offset,
  output logic                    push_valid,
  output tod_item_t               push_item,
  input  wire logic               push_ready
);

  logic               s1_v_r, s2_v_r;
  logic               s1_rdy, s2_rdy;
  mode_t              s1_mode_r, s2_mode_r;
  logic               s1_bad_r, s2_bad_r;
  logic [25:0]        s1_x_r, s2_x_r;
  logic [6:0]         s1_lo_r, s2_lo_r;
  logic [16:0]        s2_q_r;

  logic signed [33:0] sum_w, val_w;
  logic [33:0]        biased_w;
  logic               range_ok, checked, bad_w;
  logic [52:0]        qprod_w;
  logic [26:0]        qm_w, rem_w, rem_fix_w;

  assign s2_rdy   = !s2_v_r || push_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;

  // operand to seconds; exact for any 16-bit signed fields
  always_comb begin
    sum_w = 34'(in_hours_in) * 34'(SEC_PER_HOUR) +
            34'(in_minutes_in) * 34'(SEC_PER_MIN) + 34'(in_seconds_in);
    val_w = (mode_t'(in_mode) == MODE_SHIFT) ? 34'(in_offset) : sum_w;
    biased_w = val_w + DAY_BIAS;
    range_ok = (in_hours_in >= 16'sd0) && (in_hours_in <= 16'(HOUR_MAX)) &&
               (in_minutes_in >= 16'sd0) && (in_minutes_in <= 16'(MIN_MAX)) &&
               (in_seconds_in >= 16'sd0) && (in_seconds_in <= 16'(SEC_MAX));
    checked  = (mode_t'(in_mode) == MODE_SET) || (mode_t'(in_mode) == MODE_DIFF);
    bad_w    = checked && !range_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_mode_r <= mode_t'(in_mode);
      s1_bad_r  <= bad_w;
      s1_x_r    <= biased_w[32:DAY_LO_BITS];
      s1_lo_r   <= biased_w[DAY_LO_BITS-1:0];
    end
  end

  // quotient by 675 via reciprocal
  assign qprod_w = 53'(s1_x_r) * 53'(RECIP_675);

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_mode_r <= s1_mode_r;
      s2_bad_r  <= s1_bad_r;
      s2_x_r    <= s1_x_r;
      s2_lo_r   <= s1_lo_r;
      s2_q_r    <= qprod_w[RECIP_675_SHIFT+16:RECIP_675_SHIFT];
    end
  end

  // remainder by 675, rebuilt with the low bits into seconds of day
  always_comb begin
    qm_w      = 27'(s2_q_r) * 27'(DAY_ODD);
    rem_w     = 27'(s2_x_r) - qm_w;
    rem_fix_w = (rem_w >= 27'(DAY_ODD)) ? rem_w - 27'(DAY_ODD) : rem_w;
    push_item.mode = s2_mode_r;
    push_item.bad  = s2_bad_r;
    push_item.secs = {rem_fix_w[9:0], s2_lo_r};
  end

  assign push_valid = s2_v_r;

endmodule

`default_nettype wire

@@ sv/tod_queue.sv @@
// Short FIFO of classified requests between front and back ends.
// Depends on tod_pkg for the item type.
`default_nettype none

module tod_queue import tod_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_valid,
  input  wire tod_item_t  push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output tod_item_t       pop_item,
  input  wire logic       pop_ready
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tod_item_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)
        count_r <= count_r + 1'b1;
      else if (do_pop && !do_push)
        count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ sv/tod_back.sv @@
// Back end: holds the time as seconds of day, applies requests and splits into h/m/s.
// Depends on tod_pkg; fed by tod_queue, drives the result channel.
`default_nettype none

module tod_back import tod_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        pop_valid,
  input  wire tod_item_t   pop_item,
  output logic             pop_ready,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_hour_out,
  output logic [5:0]       out_minute_out,
  output logic [5:0]       out_second_out,
  output logic             out_invalid,
  output logic signed [17:0] out_difference
);

  logic [16:0]  tod_r, tod_nxt;
  logic [17:0]  sum_w;
  logic [16:0]  wrap_w;
  logic [17:0]  diff_nxt;

  logic         b0_v_r, b1_v_r, b2_v_r, b3_v_r, out_v_r;
  logic         b0_rdy, b1_rdy, b2_rdy, b3_rdy, out_rdy;
  logic         b0_bad_r, b1_bad_r, b2_bad_r, b3_bad_r;
  logic [17:0]  b0_diff_r, b1_diff_r, b2_diff_r, b3_diff_r;
  logic [16:0]  b0_secs_r, b1_secs_r;
  logic [4:0]   b1_hour_r, b2_hour_r, b3_hour_r;
  logic [11:0]  b2_rem_r, b3_rem_r;
  logic [5:0]   b3_min_r;
  logic [4:0]   out_hour_r;
  logic [5:0]   out_min_r, out_sec_r;
  logic         out_bad_r;
  logic [17:0]  out_diff_r;

  logic [29:0]  hprod_w;
  logic [16:0]  hsec_w;
  logic [20:0]  mprod_w;
  logic [11:0]  msec_w;

  assign out_rdy   = !out_v_r || !out_stall;
  assign b3_rdy    = !b3_v_r || out_rdy;
  assign b2_rdy    = !b2_v_r || b3_rdy;
  assign b1_rdy    = !b1_v_r || b2_rdy;
  assign b0_rdy    = !b0_v_r || b1_rdy;
  assign pop_ready = b0_rdy;

  // time update for the request at the queue head
  always_comb begin
    sum_w   = {1'b0, tod_r} + {1'b0, pop_item.secs};
    wrap_w  = (sum_w >= 18'(SEC_PER_DAY)) ? 17'(sum_w - 18'(SEC_PER_DAY)) : sum_w[16:0];
    tod_nxt = tod_r;
    diff_nxt = '0;
    case (pop_item.mode)
      MODE_SET:   if (!pop_item.bad) tod_nxt = pop_item.secs;
      MODE_LOAD:  tod_nxt = pop_item.secs;
      MODE_SHIFT: tod_nxt = wrap_w;
      MODE_DIFF:  if (!pop_item.bad) diff_nxt = {1'b0, tod_r} - {1'b0, pop_item.secs};
      default:    tod_nxt = tod_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r   <= '0;
      b0_v_r  <= 1'b0;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (pop_valid && b0_rdy) tod_r <= tod_nxt;
      if (b0_rdy)  b0_v_r  <= pop_valid;
      if (b1_rdy)  b1_v_r  <= b0_v_r;
      if (b2_rdy)  b2_v_r  <= b1_v_r;
      if (b3_rdy)  b3_v_r  <= b2_v_r;
      if (out_rdy) out_v_r <= b3_v_r;
    end
  end

  // split: hour by reciprocal of 225, then remainder, minute by 15, then second
  assign hprod_w = 30'(b0_secs_r[16:4]) * 30'(RECIP_225);
  assign hsec_w  = 17'(b1_hour_r) * 17'(SEC_PER_HOUR);
  assign mprod_w = 21'(b2_rem_r[11:2]) * 21'(RECIP_15);
  assign msec_w  = 12'(b3_min_r) * 12'(SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (pop_valid && b0_rdy) begin
      b0_secs_r <= tod_nxt;
      b0_bad_r  <= pop_item.bad;
      b0_diff_r <= diff_nxt;
    end
    if (b0_v_r && b1_rdy) begin
      b1_secs_r <= b0_secs_r;
      b1_hour_r <= hprod_w[RECIP_225_SHIFT+4:RECIP_225_SHIFT];
      b1_bad_r  <= b0_bad_r;
      b1_diff_r <= b0_diff_r;
    end
    if (b1_v_r && b2_rdy) begin
      b2_rem_r  <= 12'(b1_secs_r - hsec_w);
      b2_hour_r <= b1_hour_r;
      b2_bad_r  <= b1_bad_r;
      b2_diff_r <= b1_diff_r;
    end
    if (b2_v_r && b3_rdy) begin
      b3_min_r  <= mprod_w[RECIP_15_SHIFT+5:RECIP_15_SHIFT];
      b3_rem_r  <= b2_rem_r;
      b3_hour_r <= b2_hour_r;
      b3_bad_r  <= b2_bad_r;
      b3_diff_r <= b2_diff_r;
    end
    if (b3_v_r && out_rdy) begin
      out_hour_r <= b3_hour_r;
      out_min_r  <= b3_min_r;
      out_sec_r  <= 6'(b3_rem_r - msec_w);
      out_bad_r  <= b3_bad_r;
      out_diff_r <= b3_diff_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_hour_out   = out_hour_r;
  assign out_minute_out = out_min_r;
  assign out_second_out = out_sec_r;
  assign out_invalid    = out_bad_r;
  assign out_difference = $signed(out_diff_r);

  a_tod_in_day: assert property (@(posedge clk) disable iff (!rst_n)
    tod_r < 17'(SEC_PER_DAY))
    else $error("stored time beyond one day");

  a_out_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_hour_r <= 5'(HOUR_MAX)) && (out_min_r <= 6'(MIN_MAX)) &&
                (out_sec_r <= 6'(SEC_MAX)))
    else $error("h/m/s split out of range");

  a_set_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && b0_rdy && pop_item.mode == MODE_SET && !pop_item.bad)
      |=> tod_r == $past(pop_item.secs))
    else $error("checked set did not load time");

endmodule

`default_nettype wire

@@ sv/time_of_day_clock_shift_unit.sv @@
// Throughput: one request per cycle unless a stall holds the pipe;
// the seconds-of-day register updates once per request.
// Front: 2 stages (operand to seconds, reduction modulo one day via reciprocal multiply).
// Back: 1 stage time update, 3 stages h/m/s split, then the output register.
// Reset (rst_n low, synchronous) sets the time to 00:00:00 and empties every stage.
`default_nettype none

module time_of_day_clock_shift_unit import tod_pkg::*; #(
  parameter int QUEUE_DEPTH = 4  // front-to-back decoupling entries, 2 or more
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [15:0] in_hours_in,
  input  wire logic signed [15:0] in_minutes_in,
  input  wire logic signed [15:0] in_seconds_in,
  input  wire logic signed [31:0] in_offset,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              out_hour_out,
  output logic [5:0]              out_minute_out,
  output logic [5:0]              out_second_out,
  output logic                    out_invalid,
  output logic signed [17:0]      out_difference
);

  // front -> queue
  logic      fq_valid, fq_ready;
  tod_item_t fq_item;
  // queue -> back
  logic      qb_valid, qb_ready;
  tod_item_t qb_item;

  // Front classifies each request: range check for checked set and difference,
  // and folds the operand (or shift offset) to 0..86399 independent of the time.
  tod_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_hours_in   (in_hours_in),
    .in_minutes_in (in_minutes_in),
    .in_seconds_in (in_seconds_in),
    .in_offset     (in_offset),
    .push_valid    (fq_valid),
    .push_item     (fq_item),
    .push_ready    (fq_ready)
  );

  // Queue lets the front keep accepting while the result side is held off.
  tod_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_item  (fq_item),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_item   (qb_item),
    .pop_ready  (qb_ready)
  );

  // Back owns the time register: a shift is one add plus a single wrap subtract, so a new
  // request can hit the time every cycle unless stalled. The h/m/s split is pipelined after.
  tod_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (qb_valid),
    .pop_item       (qb_item),
    .pop_ready      (qb_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hour_out   (out_hour_out),
    .out_minute_out (out_minute_out),
    .out_second_out (out_second_out),
    .out_invalid    (out_invalid),
    .out_difference (out_difference)
  );

endmodule

`default_nettype wire
